>>> design/bfei_pkg.sv
// Shared types for the bit-field extract/insert pipeline.
// Holds the opcode encoding and the stage payload structs; no dependencies.
package bfei_pkg;

  typedef enum logic [1:0] {
    OP_EXTRACT_U = 2'd0,
    OP_EXTRACT_S = 2'd1,
    OP_INSERT    = 2'd2
  } opcode_t;

  // Decode stage -> shift stage.
  typedef struct packed {
    logic [1:0]  op;
    logic        wide;
    logic        in_word;
    logic        len_zero;
    logic [5:0]  pos;
    logic [6:0]  eff;
    logic [63:0] base;
    logic [63:0] ins;
  } dec_t;

  // Shift stage -> merge stage.
  typedef struct packed {
    logic [1:0]  op;
    logic        wide;
    logic        in_word;
    logic        len_zero;
    logic [5:0]  pos;
    logic [6:0]  eff;
    logic [63:0] base;
    logic [63:0] shifted;
    logic [63:0] ins_sh;
    logic [63:0] fmask;
  } shf_t;

endpackage

>>> design/bfei_cmd_if.sv
// Command channel carrying one bit-field operation per transaction.
// Standalone interface; no package dependency.
interface bfei_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic        wide;
  logic [63:0] base_word;
  logic [63:0] insert_value;
  logic [7:0]  field_pos;
  logic [7:0]  field_len;

  modport source (output valid, opcode, wide, base_word, insert_value, field_pos, field_len,
                  input ready);
  modport sink   (input valid, opcode, wide, base_word, insert_value, field_pos, field_len,
                  output ready);
endinterface

>>> design/bfei_result_if.sv
// Result channel carrying one 64-bit result word per transaction.
// Standalone interface; no package dependency.
interface bfei_result_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_word;

  modport source (output valid, result_word, input ready);
  modport sink   (input valid, result_word, output ready);
endinterface

>>> design/bfei_decode.sv
// Stage 1: range check, effective length and word masking.
// Depends on bfei_pkg.
module bfei_decode import bfei_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        up_valid,
  output logic        up_ready,
  input  logic [1:0]  opcode,
  input  logic        wide,
  input  logic [63:0] base_word,
  input  logic [63:0] insert_value,
  input  logic [7:0]  field_pos,
  input  logic [7:0]  field_len,
  output logic        dn_valid,
  input  logic        dn_ready,
  output dec_t        dn_data
);

  logic       valid;
  dec_t       data;
  dec_t       data_next;
  logic [6:0] width;
  logic [6:0] room;

  always_comb begin
    width = wide ? 7'd64 : 7'd32;
    room  = width - {1'b0, field_pos[5:0]};
    data_next.op       = opcode;
    data_next.wide     = wide;
    data_next.in_word  = field_pos < {1'b0, width};
    data_next.len_zero = (field_len == 8'd0);
    data_next.pos      = field_pos[5:0];
    data_next.eff      = (field_len < {1'b0, room}) ? field_len[6:0] : room;
    data_next.base     = wide ? base_word : {32'd0, base_word[31:0]};
    data_next.ins      = insert_value;
  end

  assign up_ready = !valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data <= data_next;
    end
  end

  assign dn_valid = valid;
  assign dn_data  = data;

endmodule

>>> design/bfei_shift.sv
// Stage 2: barrel shifts of base and insert value, field mask build.
// Depends on bfei_pkg.
module bfei_shift import bfei_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic up_valid,
  output logic up_ready,
  input  dec_t up_data,
  output logic dn_valid,
  input  logic dn_ready,
  output shf_t dn_data
);

  logic valid;
  shf_t data;
  shf_t data_next;

  always_comb begin
    data_next.op       = up_data.op;
    data_next.wide     = up_data.wide;
    data_next.in_word  = up_data.in_word;
    data_next.len_zero = up_data.len_zero;
    data_next.pos      = up_data.pos;
    data_next.eff      = up_data.eff;
    data_next.base     = up_data.base;
    data_next.shifted  = up_data.base >> up_data.pos;
    data_next.ins_sh   = up_data.ins << up_data.pos;
    // A 64-bit field (eff of 64) sets every bit
    data_next.fmask    = up_data.eff[6] ? {64{1'b1}}
                                        : ((64'd1 << up_data.eff[5:0]) - 64'd1);
  end

  assign up_ready = !valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data <= data_next;
    end
  end

  assign dn_valid = valid;
  assign dn_data  = data;

endmodule

>>> design/bfei_merge.sv
// Stage 3: sign extension, insert merge and result selection per opcode.
// Depends on bfei_pkg.
module bfei_merge import bfei_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        up_valid,
  output logic        up_ready,
  input  shf_t        up_data,
  output logic        dn_valid,
  input  logic        dn_ready,
  output logic [63:0] result_word
);

  logic        valid;
  logic [63:0] res;
  logic [63:0] res_next;
  logic [63:0] wmask;
  logic [63:0] field;
  logic [63:0] ins_mask;
  logic [5:0]  sign_idx;
  logic        sign;
  logic        top_bit;

  always_comb begin
    wmask    = up_data.wide ? {64{1'b1}} : {32'd0, {32{1'b1}}};
    field    = up_data.shifted & up_data.fmask;
    sign_idx = up_data.eff[5:0] - 6'd1;
    sign     = up_data.shifted[sign_idx];
    top_bit  = up_data.wide ? up_data.base[63] : up_data.base[31];
    ins_mask = up_data.fmask << up_data.pos;
    case (up_data.op)
      OP_EXTRACT_U: begin
        res_next = (up_data.in_word && !up_data.len_zero) ? field : 64'd0;
      end
      OP_EXTRACT_S: begin
        if (up_data.len_zero) begin
          res_next = 64'd0;
        end else if (!up_data.in_word) begin
          res_next = top_bit ? wmask : 64'd0;
        end else begin
          res_next = (field | (sign ? ~up_data.fmask : 64'd0)) & wmask;
        end
      end
      OP_INSERT: begin
        if (!up_data.in_word || up_data.len_zero) begin
          res_next = up_data.base;
        end else begin
          res_next = ((up_data.base & ~ins_mask) | (up_data.ins_sh & ins_mask)) & wmask;
        end
      end
      default: begin
        res_next = 64'd0;
      end
    endcase
  end

  assign up_ready = !valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      res <= res_next;
    end
  end

  assign dn_valid    = valid;
  assign result_word = res;

endmodule

>>> design/bit_field_extract_insert_top.sv
// Bit-field extract/insert unit, top level.
// Depends on bfei_pkg, bfei_cmd_if, bfei_result_if and the three stage modules.
//
// Usage:
//   cmd    : one operation per transaction (opcode, wide, base_word,
//            insert_value, field_pos, field_len). Opcode 0 is unsigned
//            extract, 1 signed extract, 2 insert; code 3 returns zero.
//   result : one result_word per command, in command order. In 32-bit
//            mode the upper 32 bits are zero.
//   Order: a command passes the decode, shift and merge registers in
//   turn; result.valid rises once it sits in the merge register.
//   Throughput: one command per cycle, sustained while result.ready is high.
//   The pipeline has three register stages: decode (range check and
//   effective length), shift (barrel shifts and field mask) and merge
//   (sign extension, insert and opcode select). The barrel shifters set
//   the depth of the middle stage.
//   Each stage holds its own valid bit and takes a new transaction when
//   it is empty or its successor is taking its content, so bubbles
//   collapse when the receiver stalls; a full stall backs up to cmd.ready
//   without losing or repeating a transaction.
//   Reset (rst, synchronous) empties all stages; no results are pending
//   afterwards. There is no configuration and no other state.
module bit_field_extract_insert_top import bfei_pkg::*; (
  input  logic clk,
  input  logic rst,
  bfei_cmd_if.sink      cmd,
  bfei_result_if.source result
);

  logic dec_valid;
  logic dec_ready;
  dec_t dec_data;
  logic shf_valid;
  logic shf_ready;
  shf_t shf_data;

  // Stage 1: decode the command.
  bfei_decode u_decode (
    .clk          (clk),
    .rst          (rst),
    .up_valid     (cmd.valid),
    .up_ready     (cmd.ready),
    .opcode       (cmd.opcode),
    .wide         (cmd.wide),
    .base_word    (cmd.base_word),
    .insert_value (cmd.insert_value),
    .field_pos    (cmd.field_pos),
    .field_len    (cmd.field_len),
    .dn_valid     (dec_valid),
    .dn_ready     (dec_ready),
    .dn_data      (dec_data)
  );

  // Stage 2: align the field.
  bfei_shift u_shift (
    .clk      (clk),
    .rst      (rst),
    .up_valid (dec_valid),
    .up_ready (dec_ready),
    .up_data  (dec_data),
    .dn_valid (shf_valid),
    .dn_ready (shf_ready),
    .dn_data  (shf_data)
  );

  // Stage 3: form the result; its register drives the result channel.
  bfei_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .up_valid    (shf_valid),
    .up_ready    (shf_ready),
    .up_data     (shf_data),
    .dn_valid    (result.valid),
    .dn_ready    (result.ready),
    .result_word (result.result_word)
  );

endmodule
